/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL files.
// Setting ASSERT_OFF removes every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Clocked check that is skipped while reset is asserted.
`define TICS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Clocked check that also holds during reset.
`define TICS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TICS_ASSERT(lbl, clk, rst_n, prop, msg)
`define TICS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* rtl/tics_pkg.sv */
package tics_pkg;

    // Telnet protocol bytes.
    localparam logic [7:0] BYTE_IAC  = 8'hFF;
    localparam logic [7:0] BYTE_DONT = 8'hFE;
    localparam logic [7:0] BYTE_DO   = 8'hFD;
    localparam logic [7:0] BYTE_WONT = 8'hFC;
    localparam logic [7:0] BYTE_WILL = 8'hFB;
    localparam logic [7:0] BYTE_SB   = 8'hFA;
    localparam logic [7:0] BYTE_SE   = 8'hF0;

    localparam logic [7:0] BYTE_TAB       = 8'd9;
    localparam logic [7:0] BYTE_LF        = 8'd10;
    localparam logic [7:0] BYTE_CR        = 8'd13;
    localparam logic [7:0] PRINTABLE_MIN  = 8'd32;

    localparam logic [15:0] SERVICE_PORT_RESET = 16'd23;

    localparam int COUNT_BITS_DEFAULT = 16;
    localparam int SHOWN_COUNT_W      = 16;

    typedef enum logic [2:0] {
        KIND_NONE     = 3'd0,
        KIND_SIMPLE   = 3'd1,
        KIND_NEG      = 3'd2,
        KIND_NEG_CUT  = 3'd3,
        KIND_SB_BEGIN = 3'd4
    } t_cmd_kind;

    typedef enum logic [2:0] {
        CLASS_EMPTY   = 3'd0,
        CLASS_MIXED   = 3'd1,
        CLASS_CONTROL = 3'd2,
        CLASS_TEXT    = 3'd3,
        CLASS_UNKNOWN = 3'd4
    } t_pkt_class;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        last_of_packet;
        logic        empty_packet;
        logic [15:0] source_port;
        logic [15:0] dest_port;
    } t_in_item;

    typedef struct packed {
        logic                     text_valid;
        logic [7:0]               text_byte;
        t_cmd_kind                command_kind;
        logic [7:0]               command_code;
        logic [7:0]               option_code;
        logic                     packet_done;
        logic                     is_telnet;
        t_pkt_class               packet_class;
        logic [SHOWN_COUNT_W-1:0] commands_seen;
        logic [SHOWN_COUNT_W-1:0] text_bytes_seen;
        logic                     from_server;
    } t_out_item;

    function automatic logic is_text(input logic [7:0] b);
        return (b >= PRINTABLE_MIN) || (b == BYTE_CR) || (b == BYTE_LF) || (b == BYTE_TAB);
    endfunction

    function automatic logic is_neg(input logic [7:0] b);
        return (b == BYTE_DO) || (b == BYTE_DONT) || (b == BYTE_WILL) || (b == BYTE_WONT);
    endfunction

endpackage

/* rtl/tics_in_if.sv */
interface tics_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  payload_byte;
    logic        last_of_packet;
    logic        empty_packet;
    logic [15:0] source_port;
    logic [15:0] dest_port;

    modport source (
        output valid, payload_byte, last_of_packet, empty_packet, source_port, dest_port,
        input  ready
    );
    modport sink (
        input  valid, payload_byte, last_of_packet, empty_packet, source_port, dest_port,
        output ready
    );
endinterface

/* rtl/tics_out_if.sv */
interface tics_out_if;
    logic        valid;
    logic        ready;
    logic        text_valid;
    logic [7:0]  text_byte;
    logic [2:0]  command_kind;
    logic [7:0]  command_code;
    logic [7:0]  option_code;
    logic        packet_done;
    logic        is_telnet;
    logic [2:0]  packet_class;
    logic [15:0] commands_seen;
    logic [15:0] text_bytes_seen;
    logic        from_server;

    modport source (
        output valid, text_valid, text_byte, command_kind, command_code, option_code,
               packet_done, is_telnet, packet_class, commands_seen, text_bytes_seen,
               from_server,
        input  ready
    );
    modport sink (
        input  valid, text_valid, text_byte, command_kind, command_code, option_code,
               packet_done, is_telnet, packet_class, commands_seen, text_bytes_seen,
               from_server,
        output ready
    );
endinterface

/* rtl/telnet_iac_stream_classifier_unit.sv */
// Telnet IAC stream classifier: takes one TCP payload word per cycle and, for every word,
// returns one result word that says whether the byte is text, which IAC command (simple,
// negotiation with option, negotiation cut off by the packet end, subnegotiation start)
// it completes, and on the packet's last word the packet class, direction and counts.
// Throughput is one word per clock cycle unless the result side stalls; a word passes
// through the input register and then the result register, with the parse-state update
// between them. The input register takes a new word while a finished result waits, as
// long as it is empty itself; once both registers hold words, the input stalls until the
// result word is taken. The user must write the service port register (reset 23) through
// i_cfg_we/i_cfg_wdata only while the block holds no word in flight; nothing enforces it.

`include "assert_macros.svh"

module telnet_iac_stream_classifier_unit #(
    parameter int COUNT_BITS = tics_pkg::COUNT_BITS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    tics_in_if.sink     i_in,
    tics_out_if.source  o_out
);

    logic [15:0] r_service_port;

    // Input register.
    logic               r_in_valid;
    tics_pkg::t_in_item r_in;

    // Result register.
    logic                r_out_valid;
    tics_pkg::t_out_item r_out;

    tics_pkg::t_out_item result;
    logic                out_free;
    logic                advance;
    logic                in_ready;

    // The result register frees up when it is empty or its word is being taken;
    // the input register then hands its word over and can take a new one.
    assign out_free = !r_out_valid || o_out.ready;
    assign advance  = r_in_valid && out_free;
    assign in_ready = !r_in_valid || advance;

    assign i_in.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_service_port <= tics_pkg::SERVICE_PORT_RESET;
        end else if (i_cfg_we) begin
            r_service_port <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_in.payload_byte   <= i_in.payload_byte;
            r_in.last_of_packet <= i_in.last_of_packet;
            r_in.empty_packet   <= i_in.empty_packet;
            r_in.source_port    <= i_in.source_port;
            r_in.dest_port      <= i_in.dest_port;
        end
    end

    // The parser advances its state only when the word moves on to the result register.
    tics_parser #(
        .COUNT_BITS (COUNT_BITS)
    ) u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (advance),
        .i_item         (r_in),
        .i_service_port (r_service_port),
        .o_result       (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.text_valid      = r_out.text_valid;
    assign o_out.text_byte       = r_out.text_byte;
    assign o_out.command_kind    = r_out.command_kind;
    assign o_out.command_code    = r_out.command_code;
    assign o_out.option_code     = r_out.option_code;
    assign o_out.packet_done     = r_out.packet_done;
    assign o_out.is_telnet       = r_out.is_telnet;
    assign o_out.packet_class    = r_out.packet_class;
    assign o_out.commands_seen   = r_out.commands_seen;
    assign o_out.text_bytes_seen = r_out.text_bytes_seen;
    assign o_out.from_server     = r_out.from_server;

    `TICS_ASSERT(a_advance_fills_out, i_clk, i_rst_n,
        advance |=> r_out_valid,
        "word handed over but result register is empty")
    `TICS_ASSERT(a_in_word_kept, i_clk, i_rst_n,
        r_in_valid && !advance |=> r_in_valid,
        "word in the input register was lost")
    `TICS_ASSERT(a_out_word_kept, i_clk, i_rst_n,
        r_out_valid && !o_out.ready |=> r_out_valid && $stable(r_out),
        "stalled result word changed or vanished")

endmodule

/* rtl/tics_parser.sv */
`include "assert_macros.svh"

// Per-byte parse state and the combinational result for the word at the input register.
module tics_parser #(
    parameter int COUNT_BITS = tics_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  tics_pkg::t_in_item   i_item,
    input  logic [15:0]          i_service_port,
    output tics_pkg::t_out_item  o_result
);

    typedef enum logic [4:0] {
        PH_PLAIN  = 5'b00001,
        PH_IAC    = 5'b00010,
        PH_NEG    = 5'b00100,
        PH_SB     = 5'b01000,
        PH_SB_IAC = 5'b10000
    } t_phase;

    localparam int SW = tics_pkg::SHOWN_COUNT_W;

    t_phase                r_phase, n_phase;
    logic [7:0]            r_held, n_held;
    logic [COUNT_BITS-1:0] r_cmd, n_cmd;
    logic [COUNT_BITS-1:0] r_txt, n_txt;

    logic [7:0]          pb;
    logic                last, empty, done;
    logic                plain, text_hit, cmd_bump;
    tics_pkg::t_cmd_kind kind;
    logic [7:0]          code, opt;
    tics_pkg::t_pkt_class cls;
    logic [SW-1:0]       cmd_shown, txt_shown;

    assign pb    = i_item.payload_byte;
    assign last  = i_item.last_of_packet;
    assign empty = i_item.empty_packet;
    assign done  = last || empty;

    always_comb begin
        n_phase  = r_phase;
        n_held   = r_held;
        kind     = tics_pkg::KIND_NONE;
        code     = 8'd0;
        opt      = 8'd0;
        plain    = 1'b0;
        cmd_bump = 1'b0;
        if (!empty) begin
            unique case (r_phase)
                PH_IAC: begin
                    code = pb;
                    if (tics_pkg::is_neg(pb)) begin
                        if (last) begin
                            kind     = tics_pkg::KIND_NEG_CUT;
                            cmd_bump = 1'b1;
                        end else begin
                            n_held  = pb;
                            code    = 8'd0;
                            n_phase = PH_NEG;
                        end
                    end else if (pb == tics_pkg::BYTE_SB) begin
                        kind     = tics_pkg::KIND_SB_BEGIN;
                        cmd_bump = 1'b1;
                        n_phase  = PH_SB;
                    end else begin
                        kind     = tics_pkg::KIND_SIMPLE;
                        cmd_bump = 1'b1;
                        n_phase  = PH_PLAIN;
                    end
                end
                PH_NEG: begin
                    kind     = tics_pkg::KIND_NEG;
                    code     = r_held;
                    opt      = pb;
                    cmd_bump = 1'b1;
                    n_phase  = PH_PLAIN;
                end
                PH_SB: begin
                    if (last) begin
                        plain = 1'b1;
                    end else if (pb == tics_pkg::BYTE_IAC) begin
                        n_phase = PH_SB_IAC;
                    end
                end
                PH_SB_IAC: begin
                    if (pb == tics_pkg::BYTE_SE) begin
                        n_phase = PH_PLAIN;
                    end else if (last) begin
                        plain = 1'b1;
                    end else if (pb != tics_pkg::BYTE_IAC) begin
                        n_phase = PH_SB;
                    end
                end
                default: begin
                    // Plain data; unused phase codes behave the same way.
                    if (pb == tics_pkg::BYTE_IAC) begin
                        if (!last) begin
                            n_phase = PH_IAC;
                        end
                    end else begin
                        plain = 1'b1;
                    end
                end
            endcase
        end
        text_hit = plain && (pb != tics_pkg::BYTE_IAC) && tics_pkg::is_text(pb);
        n_cmd = r_cmd;
        n_txt = r_txt;
        if (cmd_bump && (r_cmd != '1)) begin
            n_cmd = r_cmd + COUNT_BITS'(1);
        end
        if (text_hit && (r_txt != '1)) begin
            n_txt = r_txt + COUNT_BITS'(1);
        end
    end

    always_comb begin
        priority if (!done) begin
            cls = tics_pkg::CLASS_EMPTY;
        end else if (empty) begin
            cls = tics_pkg::CLASS_EMPTY;
        end else if ((n_cmd != '0) && (n_txt != '0)) begin
            cls = tics_pkg::CLASS_MIXED;
        end else if (n_cmd != '0) begin
            cls = tics_pkg::CLASS_CONTROL;
        end else if (n_txt != '0) begin
            cls = tics_pkg::CLASS_TEXT;
        end else begin
            cls = tics_pkg::CLASS_UNKNOWN;
        end
    end

    // The shown counts are clamped to the width of the result fields when the counters are wider, else widened.
    generate
        if (COUNT_BITS > SW) begin : g_clamp
            assign cmd_shown = (|n_cmd[COUNT_BITS-1:SW]) ? {SW{1'b1}} : n_cmd[SW-1:0];
            assign txt_shown = (|n_txt[COUNT_BITS-1:SW]) ? {SW{1'b1}} : n_txt[SW-1:0];
        end else begin : g_extend
            assign cmd_shown = SW'(n_cmd);
            assign txt_shown = SW'(n_txt);
        end
    endgenerate

    always_comb begin
        o_result.text_valid      = text_hit;
        o_result.text_byte       = text_hit ? pb : 8'd0;
        o_result.command_kind    = kind;
        o_result.command_code    = code;
        o_result.option_code     = opt;
        o_result.packet_done     = done;
        o_result.is_telnet       = (i_item.source_port == i_service_port)
                                || (i_item.dest_port == i_service_port);
        o_result.packet_class    = cls;
        o_result.commands_seen   = cmd_shown;
        o_result.text_bytes_seen = txt_shown;
        o_result.from_server     = (i_item.source_port == i_service_port);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PLAIN;
            r_held  <= 8'd0;
            r_cmd   <= '0;
            r_txt   <= '0;
        end else if (i_fire) begin
            if (done) begin
                r_phase <= PH_PLAIN;
                r_held  <= 8'd0;
                r_cmd   <= '0;
                r_txt   <= '0;
            end else begin
                r_phase <= n_phase;
                r_held  <= n_held;
                r_cmd   <= n_cmd;
                r_txt   <= n_txt;
            end
        end
    end

    `TICS_ASSERT(a_clear_on_done, i_clk, i_rst_n,
        i_fire && done |=> (r_phase == PH_PLAIN) && (r_cmd == '0) && (r_txt == '0),
        "parse state not cleared after packet end")
    `TICS_ASSERT(a_counts_monotonic, i_clk, i_rst_n,
        i_fire && !done |=> (r_cmd >= $past(r_cmd)) && (r_txt >= $past(r_txt)),
        "packet counter went backwards inside a packet")
    `TICS_ASSERT(a_text_xor_cmd, i_clk, i_rst_n,
        o_result.text_valid |-> (o_result.command_kind == tics_pkg::KIND_NONE),
        "a word was reported both as text and as a command")

endmodule

/* bench/telnet_iac_result_checker.sv */
`timescale 1ns / 1ps

// Watches both channels of the classifier. It predicts the result word for each accepted
// payload word and compares it with the words that come out, oldest first.
module telnet_iac_result_checker
    import tics_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    tics_in_if          i_in_mon,
    tics_out_if         i_out_mon,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int          REPORT_LIMIT = 10;
    localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

    typedef enum logic [2:0] {
        SCAN_DATA,
        SCAN_CMD,
        SCAN_OPTION,
        SCAN_SUBNEG,
        SCAN_SUBNEG_IAC
    } t_scan_phase;

    t_scan_phase scan_phase;
    logic [7:0]  held_verb;
    logic [15:0] cmd_count;
    logic [15:0] text_count;
    logic [15:0] service_port;
    t_out_item   predicted_words[$];
    int          mismatches;

    function automatic logic [15:0] sat_inc(input logic [15:0] c);
        return (c == COUNT_MAX) ? c : c + 16'd1;
    endfunction

    function automatic logic is_negotiation(input logic [7:0] b);
        return (b == BYTE_DO) || (b == BYTE_DONT) || (b == BYTE_WILL) || (b == BYTE_WONT);
    endfunction

    function automatic logic is_printable(input logic [7:0] b);
        return (b >= PRINTABLE_MIN) || (b == BYTE_CR) || (b == BYTE_LF) || (b == BYTE_TAB);
    endfunction

    // Advances the parse state by one payload word and forms the result word it causes.
    function automatic t_out_item classify_word(input t_in_item w);
        t_out_item  r;
        logic [7:0] b;
        logic       as_data;
        logic       ends;
        r       = '0;
        b       = w.payload_byte;
        as_data = 1'b0;
        ends    = w.last_of_packet || w.empty_packet;
        if (!w.empty_packet) begin
            case (scan_phase)
                SCAN_CMD: begin
                    r.command_code = b;
                    if (is_negotiation(b) && !w.last_of_packet) begin
                        held_verb      = b;
                        r.command_code = 8'h00;
                        scan_phase     = SCAN_OPTION;
                    end else begin
                        if (is_negotiation(b)) begin
                            r.command_kind = KIND_NEG_CUT;
                        end else if (b == BYTE_SB) begin
                            r.command_kind = KIND_SB_BEGIN;
                            scan_phase     = SCAN_SUBNEG;
                        end else begin
                            r.command_kind = KIND_SIMPLE;
                            scan_phase     = SCAN_DATA;
                        end
                        cmd_count = sat_inc(cmd_count);
                    end
                end
                SCAN_OPTION: begin
                    r.command_kind = KIND_NEG;
                    r.command_code = held_verb;
                    r.option_code  = b;
                    cmd_count      = sat_inc(cmd_count);
                    scan_phase     = SCAN_DATA;
                end
                SCAN_SUBNEG: begin
                    if (w.last_of_packet) begin
                        as_data = 1'b1;
                    end else if (b == BYTE_IAC) begin
                        scan_phase = SCAN_SUBNEG_IAC;
                    end
                end
                SCAN_SUBNEG_IAC: begin
                    if (b == BYTE_SE) begin
                        scan_phase = SCAN_DATA;
                    end else if (w.last_of_packet) begin
                        as_data = 1'b1;
                    end else if (b != BYTE_IAC) begin
                        scan_phase = SCAN_SUBNEG;
                    end
                end
                default: begin
                    if (b == BYTE_IAC) begin
                        if (!w.last_of_packet) begin
                            scan_phase = SCAN_CMD;
                        end
                    end else begin
                        as_data = 1'b1;
                    end
                end
            endcase
            if (as_data && b != BYTE_IAC && is_printable(b)) begin
                r.text_valid = 1'b1;
                r.text_byte  = b;
                text_count   = sat_inc(text_count);
            end
        end
        r.packet_done = ends;
        if (ends) begin
            if (w.empty_packet) begin
                r.packet_class = CLASS_EMPTY;
            end else if (cmd_count != 0 && text_count != 0) begin
                r.packet_class = CLASS_MIXED;
            end else if (cmd_count != 0) begin
                r.packet_class = CLASS_CONTROL;
            end else if (text_count != 0) begin
                r.packet_class = CLASS_TEXT;
            end else begin
                r.packet_class = CLASS_UNKNOWN;
            end
        end
        r.is_telnet       = (w.source_port == service_port) || (w.dest_port == service_port);
        r.from_server     = (w.source_port == service_port);
        r.commands_seen   = cmd_count;
        r.text_bytes_seen = text_count;
        if (ends) begin
            scan_phase = SCAN_DATA;
            held_verb  = 8'h00;
            cmd_count  = '0;
            text_count = '0;
        end
        return r;
    endfunction

    function automatic string show(input t_out_item r);
        string head;
        head = $sformatf("text=%0b/%02h kind=%0d cmd=%02h opt=%02h done=%0b",
                         r.text_valid, r.text_byte, r.command_kind, r.command_code,
                         r.option_code, r.packet_done);
        return {head, $sformatf(" telnet=%0b class=%0d cmds=%0d texts=%0d server=%0b",
                                r.is_telnet, r.packet_class, r.commands_seen,
                                r.text_bytes_seen, r.from_server)};
    endfunction

    always @(posedge i_clk) begin
        t_in_item  word;
        t_out_item want;
        t_out_item got;
        logic      bad;
        if (!i_rst_n) begin
            scan_phase   = SCAN_DATA;
            held_verb    = 8'h00;
            cmd_count    = '0;
            text_count   = '0;
            service_port = SERVICE_PORT_RESET;
            mismatches   = 0;
            predicted_words.delete();
        end else begin
            if (i_cfg_we) begin
                service_port = i_cfg_wdata;
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                word.payload_byte   = i_in_mon.payload_byte;
                word.last_of_packet = i_in_mon.last_of_packet;
                word.empty_packet   = i_in_mon.empty_packet;
                word.source_port    = i_in_mon.source_port;
                word.dest_port      = i_in_mon.dest_port;
                predicted_words.insert(predicted_words.size(), classify_word(word));
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                got.text_valid      = i_out_mon.text_valid;
                got.text_byte       = i_out_mon.text_byte;
                got.command_kind    = t_cmd_kind'(i_out_mon.command_kind);
                got.command_code    = i_out_mon.command_code;
                got.option_code     = i_out_mon.option_code;
                got.packet_done     = i_out_mon.packet_done;
                got.is_telnet       = i_out_mon.is_telnet;
                got.packet_class    = t_pkt_class'(i_out_mon.packet_class);
                got.commands_seen   = i_out_mon.commands_seen;
                got.text_bytes_seen = i_out_mon.text_bytes_seen;
                got.from_server     = i_out_mon.from_server;
                if (predicted_words.size() == 0) begin
                    if (mismatches < REPORT_LIMIT) begin
                        $display("unexpected result word: %s", show(got));
                    end
                    mismatches++;
                end else begin
                    want = predicted_words.pop_front();
                    bad  = (want.text_valid      !== got.text_valid)
                        || (want.text_byte       !== got.text_byte)
                        || (want.command_kind    !== got.command_kind)
                        || (want.command_code    !== got.command_code)
                        || (want.option_code     !== got.option_code)
                        || (want.packet_done     !== got.packet_done)
                        || (want.is_telnet       !== got.is_telnet)
                        || (want.packet_class    !== got.packet_class)
                        || (want.commands_seen   !== got.commands_seen)
                        || (want.text_bytes_seen !== got.text_bytes_seen)
                        || (want.from_server     !== got.from_server);
                    if (bad) begin
                        if (mismatches < REPORT_LIMIT) begin
                            $display("result mismatch at %0t", $time);
                            $display("  expected %s", show(want));
                            $display("  actual   %s", show(got));
                        end
                        mismatches++;
                    end
                end
            end
        end
        o_pending    <= predicted_words.size();
        o_fail_count <= mismatches;
    end

endmodule

/* bench/telnet_iac_stream_classifier_unit_test.sv */
`timescale 1ns / 1ps

// Test of the Telnet IAC stream classifier. This module only makes stimulus and gives the
// verdict; the checker beside the block predicts every result word and compares.
module telnet_iac_stream_classifier_unit_test;
    import tics_pkg::*;

    // Roughly a quarter of the random words go into each service port setting.
    localparam int WORDS_PER_PHASE = 256;
    // The one long receiver stall, long enough for the block to fill and stall its input.
    localparam int HOLD_OFF_CYCLES = 200;
    // Many times the longest quiet stretch of a correct run (the hold-off above).
    localparam int WATCHDOG_LIMIT  = 3000;
    // Wait after the last expected result word, to catch any stray word that follows.
    localparam int DRAIN_CYCLES    = 6;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    int          fail_count;
    int          pending_words;
    int          idle_cycles = 0;

    // The service port as the stimulus knows it, so that packets can be aimed at it.
    logic [15:0] service_port;
    // When set, neither side idles; this gives stretches of full-rate traffic.
    bit          steady_flow;
    // Raised by the stimulus once; the receiver then holds off for a long stretch.
    bit          hold_off_req;
    logic [7:0]  pkt_bytes[$];

    tics_in_if  in_bus ();
    tics_out_if out_bus ();

    telnet_iac_stream_classifier_unit u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_bus),
        .o_out       (out_bus)
    );

    telnet_iac_result_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_mon     (in_bus),
        .i_out_mon    (out_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending_words)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Idle lengths: half of them none, most of the rest short, a few long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Text as a terminal would send it: mostly printable ASCII, some line control, and a
    // share of high bytes, which the block also counts as text.
    function automatic logic [7:0] pick_text();
        case ($urandom_range(0, 9))
            0:       return BYTE_TAB;
            1:       return BYTE_LF;
            2:       return BYTE_CR;
            3:       return 8'($urandom_range(128, 254));
            default: return 8'($urandom_range(32, 126));
        endcase
    endfunction

    function automatic logic [7:0] pick_verb();
        case ($urandom_range(0, 3))
            0:       return BYTE_DO;
            1:       return BYTE_DONT;
            2:       return BYTE_WILL;
            default: return BYTE_WONT;
        endcase
    endfunction

    // Appends one byte to the packet under construction.
    function automatic void add_byte(input logic [7:0] b);
        pkt_bytes.insert(pkt_bytes.size(), b);
    endfunction

    // Offers one word and returns at the edge where it is taken. Valid is lowered only when
    // a gap comes before the word, so it is never dropped and raised within one step.
    task automatic send_word(input t_in_item w);
        int gap;
        gap = steady_flow ? 0 : pick_gap();
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_bus.valid          <= 1'b1;
        in_bus.payload_byte   <= w.payload_byte;
        in_bus.last_of_packet <= w.last_of_packet;
        in_bus.empty_packet   <= w.empty_packet;
        in_bus.source_port    <= w.source_port;
        in_bus.dest_port      <= w.dest_port;
        do @(posedge clk); while (!in_bus.ready);
    endtask

    // Sends the bytes in pkt_bytes as one packet. Without the end marker the parser simply
    // runs on into the next packet.
    task automatic send_packet(input logic [15:0] sp, input logic [15:0] dp,
                               input bit with_end);
        t_in_item w;
        for (int i = 0; i < pkt_bytes.size(); i++) begin
            w.payload_byte   = pkt_bytes[i];
            w.last_of_packet = with_end && (i == pkt_bytes.size() - 1);
            w.empty_packet   = 1'b0;
            w.source_port    = sp;
            w.dest_port      = dp;
            send_word(w);
        end
    endtask

    // An empty packet carries only its end; the payload byte must be ignored.
    task automatic send_empty(input logic [15:0] sp, input logic [15:0] dp, input bit last);
        t_in_item w;
        w.payload_byte   = 8'($urandom_range(0, 255));
        w.last_of_packet = last;
        w.empty_packet   = 1'b1;
        w.source_port    = sp;
        w.dest_port      = dp;
        send_word(w);
    endtask

    // Builds a packet from well-formed Telnet pieces with random content. Some packets are
    // cut short at a random point, which leaves commands and subnegotiations open at the
    // packet end.
    task automatic compose_packet();
        int pieces;
        int n;
        pkt_bytes.delete();
        pieces = $urandom_range(1, 6);
        repeat (pieces) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    n = $urandom_range(1, 4);
                    repeat (n) add_byte(pick_text());
                end
                3: begin
                    // Any command byte; the upper range holds the named Telnet commands.
                    add_byte(BYTE_IAC);
                    if ($urandom_range(0, 1) == 0) begin
                        add_byte(8'($urandom_range(8'hF0, 8'hFF)));
                    end else begin
                        add_byte(8'($urandom_range(0, 255)));
                    end
                end
                4, 5: begin
                    add_byte(BYTE_IAC);
                    add_byte(pick_verb());
                    add_byte(8'($urandom_range(0, 255)));
                end
                6: begin
                    // Subnegotiation body, with an escaped IAC now and then.
                    add_byte(BYTE_IAC);
                    add_byte(BYTE_SB);
                    n = $urandom_range(0, 4);
                    repeat (n) begin
                        if ($urandom_range(0, 4) == 0) begin
                            add_byte(BYTE_IAC);
                            add_byte(BYTE_IAC);
                        end else begin
                            add_byte(8'($urandom_range(0, 255)));
                        end
                    end
                    add_byte(BYTE_IAC);
                    add_byte(BYTE_SE);
                end
                7: add_byte(8'($urandom_range(0, 31)));
                8: add_byte(8'($urandom_range(0, 255)));
                default: begin
                    add_byte(BYTE_IAC);
                    add_byte(BYTE_IAC);
                end
            endcase
        end
        if ($urandom_range(0, 6) == 0) begin
            n = $urandom_range(1, pkt_bytes.size());
            while (pkt_bytes.size() > n) void'(pkt_bytes.pop_back());
        end
    endtask

    // Waits until every expected result word has come back, then a little longer. The
    // pending count is registered and lags each acceptance, hence the first wait for an edge.
    task automatic drain();
        in_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending_words != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_service_port(input logic [15:0] value);
        cfg_we       <= 1'b1;
        cfg_wdata    <= value;
        service_port  = value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Random traffic under one service port setting. Packets are aimed at the service port
    // from either side or both, or miss it entirely.
    task automatic run_random_phase(input bit with_hold_off);
        int          sent;
        bit          hold_armed;
        logic [15:0] sp;
        logic [15:0] dp;
        sent       = 0;
        hold_armed = with_hold_off;
        while (sent < WORDS_PER_PHASE) begin
            if ($urandom_range(0, 9) == 0) begin
                steady_flow = !steady_flow;
            end
            if (hold_armed && sent >= 60) begin
                hold_off_req = 1'b1;
                hold_armed   = 1'b0;
            end
            sp = 16'($urandom_range(0, 65535));
            dp = 16'($urandom_range(0, 65535));
            case ($urandom_range(0, 4))
                0: sp = service_port;
                1: dp = service_port;
                2: begin
                    sp = service_port;
                    dp = service_port;
                end
                default: ;
            endcase
            if ($urandom_range(0, 19) == 0) begin
                send_empty(sp, dp, $urandom_range(0, 1));
                sent++;
            end else begin
                compose_packet();
                send_packet(sp, dp, $urandom_range(0, 19) != 0);
                sent += pkt_bytes.size();
            end
        end
        steady_flow = 1'b0;
    endtask

    // Result side: random stalls, a long hold-off when asked, and full-rate stretches.
    // Ready is assigned once per step at most.
    initial begin : result_sink
        int stall;
        out_bus.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_off_req) begin
                stall        = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end else begin
                stall = steady_flow ? 0 : pick_gap();
            end
            if (stall > 0) begin
                out_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    // The watchdog counts cycles in which no word moves on either side.
    always @(posedge clk) begin
        if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[telnet_iac_stream_classifier_unit] ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        rst_n                 <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_wdata             <= '0;
        in_bus.valid          <= 1'b0;
        in_bus.payload_byte   <= '0;
        in_bus.last_of_packet <= 1'b0;
        in_bus.empty_packet   <= 1'b0;
        in_bus.source_port    <= '0;
        in_bus.dest_port      <= '0;
        steady_flow  = 1'b0;
        hold_off_req = 1'b0;
        service_port = SERVICE_PORT_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed packets run under the reset service port.
        // Line control only, ending in a control byte that is dropped: a text-only packet
        // from the server side.
        pkt_bytes = {BYTE_TAB, BYTE_LF, BYTE_CR, 8'h1F};
        send_packet(SERVICE_PORT_RESET, 16'h0400, 1'b1);
        // Escaped IAC, a refusal with the highest option, and a negotiation cut off by the
        // packet end, between ports at the extremes that are not Telnet.
        pkt_bytes = {BYTE_IAC, BYTE_IAC, BYTE_IAC, BYTE_WONT, 8'hFF, BYTE_IAC, BYTE_DONT};
        send_packet(16'h0000, 16'hFFFF, 1'b1);
        // A closed subnegotiation, text after it, and a lone IAC at the end that is dropped.
        pkt_bytes = {BYTE_IAC, BYTE_SB, 8'h18, BYTE_IAC, BYTE_SE, 8'h5A, BYTE_IAC};
        send_packet(16'hABCD, SERVICE_PORT_RESET, 1'b1);
        // An unclosed subnegotiation: its last byte comes out as plain text.
        pkt_bytes = {BYTE_IAC, BYTE_SB, 8'h41, 8'h42};
        send_packet(SERVICE_PORT_RESET, SERVICE_PORT_RESET, 1'b1);
        // An empty packet, then a packet with neither text nor commands.
        send_empty(16'hFFFF, SERVICE_PORT_RESET, 1'b1);
        pkt_bytes = {8'h01};
        send_packet(16'h5A5A, 16'hA5A5, 1'b1);
        drain();

        // Random phases under both extremes of the service port, a random value, and the
        // reset value again. The long hold-off falls in the second phase.
        write_service_port(16'h0000);
        run_random_phase(1'b0);
        drain();
        write_service_port(16'hFFFF);
        run_random_phase(1'b1);
        drain();
        write_service_port(16'($urandom_range(1, 65534)));
        run_random_phase(1'b0);
        drain();
        write_service_port(SERVICE_PORT_RESET);
        run_random_phase(1'b0);
        drain();

        if (fail_count == 0) begin
            $display("[telnet_iac_stream_classifier_unit] OK");
        end else begin
            $display("[telnet_iac_stream_classifier_unit] ERROR");
        end
        $finish;
    end

endmodule

/* telnet_iac_stream_classifier_unit.f */
+incdir+rtl
rtl/tics_pkg.sv
rtl/tics_in_if.sv
rtl/tics_out_if.sv
rtl/tics_parser.sv
rtl/telnet_iac_stream_classifier_unit.sv
bench/telnet_iac_result_checker.sv
bench/telnet_iac_stream_classifier_unit_test.sv
